>>> hdl/unicode_byte_stream_decoder_defines.svh
// Assertion macros for the byte stream decoder.
`ifndef UNICODE_BYTE_STREAM_DECODER_DEFINES_SVH
`define UNICODE_BYTE_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTH
`define UBSD_ASSERT_IMM(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define UBSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UBSD_ASSERT_IMM(lbl, ante, cons)
`define UBSD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> hdl/ubsd_pkg.sv
package ubsd_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CFG_ADDR_W      = 3;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_AW         = $clog2(FIFO_DEPTH);

  localparam logic REG_ENCODING_MODE = 1'b0;

  localparam logic [2:0] MODE_UTF8    = 3'd0;
  localparam logic [2:0] MODE_UTF16LE = 3'd1;
  localparam logic [2:0] MODE_UTF16BE = 3'd2;
  localparam logic [2:0] MODE_UTF32LE = 3'd3;
  localparam logic [2:0] MODE_UTF32BE = 3'd4;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TRUNC   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [31:0] CP_LIMIT   = 32'h0011_0000;
  localparam logic [31:0] SURR_FIRST = 32'h0000_D800;
  localparam logic [31:0] SURR_LAST  = 32'h0000_DFFF;
  localparam logic [31:0] SUPP_BASE  = 32'h0001_0000;
  localparam logic [15:0] SURR_MASK  = 16'hFC00;
  localparam logic [15:0] HIGH_SURR  = 16'hD800;
  localparam logic [15:0] LOW_SURR   = 16'hDC00;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] code_point;
    logic [1:0]  status;
    logic [15:0] bytes_read;
    logic [15:0] chars_decoded;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic       en;
    logic [2:0] mode;
  } cfg_wr_t;

endpackage

>>> hdl/ubsd_ifs.sv
interface ubsd_in_if
  import ubsd_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface ubsd_out_if
  import ubsd_pkg::*;
;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] code_point;
  logic [1:0]  status;
  logic [15:0] bytes_read;
  logic [15:0] chars_decoded;
  logic        last_result;

  modport source (output valid, output result_kind, output code_point, output status,
                  output bytes_read, output chars_decoded, output last_result,
                  input ready);
  modport sink (input valid, input result_kind, input code_point, input status,
                input bytes_read, input chars_decoded, input last_result,
                output ready);
endinterface

>>> hdl/unicode_byte_stream_decoder.sv
// Path: an accepted byte is held in the input stage register, decoded once the result
// queue has room for two results, and written to the queue, whose head drives out_chan.
// Throughput: one byte per cycle while the queue has room for two results; the
// end-of-buffer byte that also completes a character yields two results, and the out
// side drains one result per cycle while ready is high, from a four-entry result queue.
// Reset: synchronous, active low; clears decode state, counters, queue and sets UTF-8.
`include "unicode_byte_stream_decoder_defines.svh"

module unicode_byte_stream_decoder
  import ubsd_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ubsd_in_if.sink               in_chan,
  ubsd_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_wr_t          cfg;
  logic [2:0]       mode;
  push_t            push;
  result_t          head;
  logic             room_two;
  logic [FIFO_AW:0] level;

  assign pready   = 1'b1;
  assign cfg.en   = psel && penable && pwrite && (paddr[2] == REG_ENCODING_MODE);
  assign cfg.mode = pwdata[2:0];
  assign prdata   = (paddr[2] == REG_ENCODING_MODE) ? 32'(mode) : '0;

  ubsd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_byte  (in_chan.data_byte),
    .in_eob   (in_chan.end_of_buffer),
    .room_two (room_two),
    .cfg      (cfg),
    .mode     (mode),
    .push     (push)
  );

  ubsd_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .head      (head),
    .room_two  (room_two),
    .level     (level)
  );

  assign out_chan.result_kind   = head.result_kind;
  assign out_chan.code_point    = head.code_point;
  assign out_chan.status        = head.status;
  assign out_chan.bytes_read    = head.bytes_read;
  assign out_chan.chars_decoded = head.chars_decoded;
  assign out_chan.last_result   = head.last_result;

  `UBSD_ASSERT_IMM(a_pair_shape, push.cnt == 2'd2,
    push.r0.result_kind == KIND_CHAR && push.r1.result_kind == KIND_STATUS &&
    !push.r0.last_result && push.r1.last_result)
  `UBSD_ASSERT_IMM(a_level_bound, 1'b1, level <= (FIFO_AW + 1)'(FIFO_DEPTH))
  `UBSD_ASSERT_IMM(a_char_ok, out_chan.valid && out_chan.result_kind == KIND_CHAR,
    out_chan.status == ST_OK)
  `UBSD_ASSERT_NXT(a_push_visible, push.cnt != 2'd0, out_chan.valid)

endmodule

>>> hdl/ubsd_rq.sv
module ubsd_rq
  import ubsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  push_t                push,
  input  logic                 out_ready,
  output logic                 out_valid,
  output result_t              head,
  output logic                 room_two,
  output logic [FIFO_AW:0]     level
);

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt, wr_ptr_inc;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]     level_r, level_nxt;
  logic                 pop;

  assign pop        = out_ready && (level_r != '0);
  assign out_valid  = (level_r != '0);
  assign head       = mem[rd_ptr_r];
  assign room_two   = (level_r <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
  assign level      = level_r;
  assign wr_ptr_inc = FIFO_AW'(wr_ptr_r + 1'b1);

  always_comb begin
    wr_ptr_nxt = FIFO_AW'(wr_ptr_r + FIFO_AW'(push.cnt));
    rd_ptr_nxt = pop ? FIFO_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    level_nxt  = (FIFO_AW + 1)'(level_r + (FIFO_AW + 1)'(push.cnt) - (FIFO_AW + 1)'(pop));
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_inc] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

>>> hdl/ubsd_core.sv
module ubsd_core
  import ubsd_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_eob,
  input  logic       room_two,
  input  cfg_wr_t    cfg,
  output logic [2:0] mode,
  output push_t      push
);

  logic                   stage_v_r, stage_v_nxt;
  logic [7:0]             byte_r;
  logic                   eob_r;
  logic                   accept, advance;

  logic [2:0]             mode_r, mode_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic [1:0]             pend_r, pend_nxt;
  logic [2:0]             exp_r, exp_nxt;
  logic [9:0]             hsb_r, hsb_nxt;
  logic                   hsh_r, hsh_nxt;
  logic                   disc_r, disc_nxt;
  logic [COUNT_WIDTH-1:0] rd_r, rd_nxt;
  logic [COUNT_WIDTH-1:0] ch_r, ch_nxt;

  logic                   emit, invalid, ftrunc, trunc;
  logic [31:0]            ch_val, acc_upd;
  logic [2:0]             ch_len, got;
  logic [15:0]            unit;
  result_t                char_res, stat_res;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] v,
                                                     input logic [2:0] d);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, v} + {{(COUNT_WIDTH - 2){1'b0}}, d};
    return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
  endfunction

  assign accept   = in_valid && in_ready;
  assign advance  = stage_v_r && room_two;
  assign in_ready = !stage_v_r || room_two;
  assign mode     = mode_r;

  always_comb begin
    if (accept) begin
      stage_v_nxt = 1'b1;
    end else if (advance) begin
      stage_v_nxt = 1'b0;
    end else begin
      stage_v_nxt = stage_v_r;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    exp_nxt  = exp_r;
    hsb_nxt  = hsb_r;
    hsh_nxt  = hsh_r;
    disc_nxt = disc_r;
    rd_nxt   = rd_r;
    ch_nxt   = ch_r;
    emit     = 1'b0;
    invalid  = 1'b0;
    ftrunc   = 1'b0;
    trunc    = 1'b0;
    ch_val   = '0;
    ch_len   = '0;
    acc_upd  = '0;
    got      = '0;
    unit     = '0;
    char_res = '0;
    stat_res = '0;
    push     = '0;

    if (advance) begin
      if (disc_r) begin
        if (eob_r) begin
          acc_nxt  = '0;
          pend_nxt = '0;
          exp_nxt  = '0;
          hsb_nxt  = '0;
          hsh_nxt  = 1'b0;
          disc_nxt = 1'b0;
          rd_nxt   = '0;
          ch_nxt   = '0;
        end
      end else begin
        case (mode_r)
          MODE_UTF8: begin
            got     = {1'b0, pend_r} + 3'd1;
            acc_upd = {acc_r[25:0], byte_r[5:0]};
            if (exp_r == 3'd0) begin
              if (byte_r[7] == 1'b0) begin
                emit   = 1'b1;
                ch_val = {24'd0, byte_r};
                ch_len = 3'd1;
              end else if ((byte_r & 8'hE0) == 8'hC0) begin
                acc_nxt  = {27'd0, byte_r[4:0]};
                exp_nxt  = 3'd2;
                pend_nxt = 2'd1;
              end else if ((byte_r & 8'hF0) == 8'hE0) begin
                acc_nxt  = {28'd0, byte_r[3:0]};
                exp_nxt  = 3'd3;
                pend_nxt = 2'd1;
              end else if ((byte_r & 8'hF8) == 8'hF0) begin
                acc_nxt  = {29'd0, byte_r[2:0]};
                exp_nxt  = 3'd4;
                pend_nxt = 2'd1;
              end else begin
                invalid = 1'b1;
              end
            end else if ((byte_r & 8'hC0) != 8'h80) begin
              if (eob_r && (got < exp_r)) begin
                ftrunc = 1'b1;
              end else begin
                invalid = 1'b1;
              end
            end else if (got >= exp_r) begin
              acc_nxt  = '0;
              pend_nxt = '0;
              exp_nxt  = '0;
              hsb_nxt  = '0;
              hsh_nxt  = 1'b0;
              if ((acc_upd >= CP_LIMIT) ||
                  ((acc_upd >= SURR_FIRST) && (acc_upd <= SURR_LAST))) begin
                invalid = 1'b1;
              end else begin
                emit   = 1'b1;
                ch_val = acc_upd;
                ch_len = exp_r;
              end
            end else begin
              acc_nxt  = acc_upd;
              pend_nxt = got[1:0];
            end
          end
          MODE_UTF16LE, MODE_UTF16BE: begin
            if (mode_r == MODE_UTF16LE) begin
              acc_upd = pend_r[0] ? (acc_r | {16'd0, byte_r, 8'd0})
                                  : (acc_r | {24'd0, byte_r});
            end else begin
              acc_upd = {acc_r[23:0], byte_r};
            end
            unit = acc_upd[15:0];
            if (pend_r == 2'd0) begin
              acc_nxt  = acc_upd;
              pend_nxt = 2'd1;
            end else begin
              acc_nxt  = '0;
              pend_nxt = '0;
              if (hsh_r) begin
                hsh_nxt = 1'b0;
                hsb_nxt = '0;
                if ((unit & SURR_MASK) == LOW_SURR) begin
                  emit   = 1'b1;
                  ch_val = {12'd0, hsb_r, unit[9:0]} + SUPP_BASE;
                  ch_len = 3'd4;
                end else begin
                  invalid = 1'b1;
                end
              end else if ((unit & SURR_MASK) == HIGH_SURR) begin
                hsb_nxt = unit[9:0];
                hsh_nxt = 1'b1;
              end else if ((unit & SURR_MASK) == LOW_SURR) begin
                invalid = 1'b1;
              end else begin
                emit   = 1'b1;
                ch_val = {16'd0, unit};
                ch_len = 3'd2;
              end
            end
          end
          MODE_UTF32LE, MODE_UTF32BE: begin
            if (mode_r == MODE_UTF32LE) begin
              acc_upd = acc_r | ({24'd0, byte_r} << {pend_r, 3'b000});
            end else begin
              acc_upd = {acc_r[23:0], byte_r};
            end
            if (pend_r == 2'd3) begin
              acc_nxt  = '0;
              pend_nxt = '0;
              exp_nxt  = '0;
              hsb_nxt  = '0;
              hsh_nxt  = 1'b0;
              emit     = 1'b1;
              ch_val   = acc_upd;
              ch_len   = 3'd4;
            end else begin
              acc_nxt  = acc_upd;
              pend_nxt = 2'(pend_r + 2'd1);
            end
          end
          default: begin
            invalid = 1'b1;
          end
        endcase

        if (emit) begin
          rd_nxt = sat_add(rd_r, ch_len);
          ch_nxt = sat_add(ch_r, 3'd1);
        end

        char_res.result_kind   = KIND_CHAR;
        char_res.code_point    = ch_val;
        char_res.status        = ST_OK;
        char_res.bytes_read    = 16'(rd_nxt);
        char_res.chars_decoded = 16'(ch_nxt);
        char_res.last_result   = !(invalid || eob_r);

        trunc = ftrunc || (pend_nxt != 2'd0) || (exp_nxt != 3'd0) || hsh_nxt;

        stat_res.result_kind   = KIND_STATUS;
        stat_res.code_point    = '0;
        stat_res.status        = invalid ? ST_INVALID : (trunc ? ST_TRUNC : ST_OK);
        stat_res.bytes_read    = 16'(rd_nxt);
        stat_res.chars_decoded = 16'(ch_nxt);
        stat_res.last_result   = 1'b1;

        if (emit) begin
          push.r0  = char_res;
          push.cnt = 2'd1;
          if (invalid || eob_r) begin
            push.r1  = stat_res;
            push.cnt = 2'd2;
          end
        end else if (invalid || eob_r) begin
          push.r0  = stat_res;
          push.cnt = 2'd1;
        end

        if (invalid || eob_r) begin
          acc_nxt  = '0;
          pend_nxt = '0;
          exp_nxt  = '0;
          hsb_nxt  = '0;
          hsh_nxt  = 1'b0;
        end
        if (eob_r) begin
          disc_nxt = 1'b0;
          rd_nxt   = '0;
          ch_nxt   = '0;
        end else if (invalid) begin
          disc_nxt = 1'b1;
        end
      end
    end

    if (cfg.en) begin
      mode_nxt = cfg.mode;
      acc_nxt  = '0;
      pend_nxt = '0;
      exp_nxt  = '0;
      hsb_nxt  = '0;
      hsh_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
      eob_r  <= in_eob;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      mode_r    <= MODE_UTF8;
      acc_r     <= '0;
      pend_r    <= '0;
      exp_r     <= '0;
      hsb_r     <= '0;
      hsh_r     <= 1'b0;
      disc_r    <= 1'b0;
      rd_r      <= '0;
      ch_r      <= '0;
    end else begin
      stage_v_r <= stage_v_nxt;
      mode_r    <= mode_nxt;
      acc_r     <= acc_nxt;
      pend_r    <= pend_nxt;
      exp_r     <= exp_nxt;
      hsb_r     <= hsb_nxt;
      hsh_r     <= hsh_nxt;
      disc_r    <= disc_nxt;
      rd_r      <= rd_nxt;
      ch_r      <= ch_nxt;
    end
  end

endmodule
